// ----- rtl/ttbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ttbc_pkg;

    localparam int STATUS_W = 3;
    localparam int TEMPO_W  = 16;
    localparam int ERR_W    = 14;
    localparam int BEATS_W  = 32;
    localparam int MAXB_W   = 8;
    localparam int SCALE_W  = 23;

    typedef enum logic [STATUS_W-1:0] {
        ST_FIRST = 3'd0,
        ST_BEAT  = 3'd1,
        ST_FAST  = 3'd2,
        ST_GAP   = 3'd3,
        ST_CLEAR = 3'd4
    } t_status;

    localparam logic               OP_TAP   = 1'b0;
    localparam logic               OP_CLEAR = 1'b1;

    // 60000 ms per minute, tempo kept in hundredths
    localparam logic [SCALE_W-1:0] TEMPO_SCALE   = 23'd6000000;
    localparam logic [15:0]        FAST_LIMIT    = 16'd60000;
    localparam logic [ERR_W-1:0]   ERR_SCALE     = 14'd10000;
    localparam logic [TEMPO_W-1:0] TEMPO_SAT     = 16'hFFFF;
    localparam logic [BEATS_W-1:0] BEATS_SAT     = 32'hFFFF_FFFF;
    localparam logic [MAXB_W-1:0]  MAX_BPM_LIMIT = 8'd250;
    localparam logic [MAXB_W-1:0]  MAX_BPM_RESET = 8'd250;

endpackage

`default_nettype wire

// ----- rtl/tap_tempo_bpm_counter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Path from accept to result: a clear and a first tap go straight to the output register;
// an ignored tap passes the fast test, a gap restart the fast and gap tests, and a counted
// beat the fast test, the gap test once it applies, the count and the divider. One item at
// a time: the input stays stalled until the result is loaded into the output register. A
// counted beat runs the shared 17-step restoring divider twice (tempo, then error).
// Reset: synchronous, active low; clears the counter, the stamps and max_bpm to 250.
module tap_tempo_bpm_counter_unit #(
    parameter int TIME_WIDTH = 32,
    parameter int GAP_LIMIT  = 5
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    input  wire logic                           i_cfg_we,
    input  wire logic [ttbc_pkg::MAXB_W-1:0]    i_cfg_wdata,

    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_op,
    input  wire logic [TIME_WIDTH-1:0]          i_time_ms,

    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output ttbc_pkg::t_status                   o_status,
    output logic [ttbc_pkg::TEMPO_W-1:0]        o_bpm_x100,
    output logic [ttbc_pkg::ERR_W-1:0]          o_error_x100,
    output logic [ttbc_pkg::BEATS_W-1:0]        o_beat_count
);

    import ttbc_pkg::*;

    localparam int AW  = (TIME_WIDTH > BEATS_W) ? TIME_WIDTH : BEATS_W;
    localparam int PW  = AW + SCALE_W;
    localparam int QW  = TEMPO_W;
    localparam int CNW = $clog2(QW + 1);

    localparam logic [PW-1:0] GAP_PROD = PW'(TEMPO_SCALE) * PW'(GAP_LIMIT);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_FAST_MUL,
        S_FAST_CHK,
        S_GAP_MUL,
        S_GAP_CHK,
        S_COUNT,
        S_TEMPO_MUL,
        S_DIV,
        S_TEMPO_WB,
        S_ERR_WB,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic                   r_started;
    logic [BEATS_W-1:0]     r_beats;
    logic [TIME_WIDTH-1:0]  r_start;
    logic [TIME_WIDTH-1:0]  r_last;
    logic [TEMPO_W-1:0]     r_tempo;
    logic [ERR_W-1:0]       r_error;
    logic [MAXB_W-1:0]      r_max_bpm;

    logic                   r_op;
    logic [TIME_WIDTH-1:0]  r_now;
    logic [TIME_WIDTH-1:0]  r_interval;
    logic [PW-1:0]          r_prod;
    logic [PW-1:0]          r_rem;
    logic [PW-1:0]          r_dvs;
    logic [QW:0]            r_quo;
    logic [CNW-1:0]         r_cnt;
    logic                   r_div_err;
    t_status                r_status;

    logic                   r_out_valid;
    t_status                r_out_status;
    logic [TEMPO_W-1:0]     r_out_tempo;
    logic [ERR_W-1:0]       r_out_error;
    logic [BEATS_W-1:0]     r_out_beats;

    logic [AW-1:0]          mul_a;
    logic [SCALE_W-1:0]     mul_b;
    logic [PW-1:0]          mul_p;
    logic [PW:0]            div_diff;
    logic                   div_ge;
    logic [TIME_WIDTH-1:0]  elapsed;

    // shared multiplier operands
    always_comb begin
        mul_a = AW'(r_interval);
        mul_b = SCALE_W'({r_max_bpm, 1'b0});
        case (r_state)
            S_GAP_MUL: begin
                mul_b = SCALE_W'(r_tempo);
            end
            S_TEMPO_MUL: begin
                mul_a = AW'(r_beats);
                mul_b = TEMPO_SCALE;
            end
            default: begin
            end
        endcase
    end

    assign mul_p    = {{SCALE_W{1'b0}}, mul_a} * {{AW{1'b0}}, mul_b};
    assign div_diff = {1'b0, r_rem} - {1'b0, r_dvs};
    assign div_ge   = ~div_diff[PW];
    assign elapsed  = r_now - r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_beats     <= '0;
            r_start     <= '0;
            r_last      <= '0;
            r_tempo     <= '0;
            r_error     <= '0;
            r_max_bpm   <= MAX_BPM_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_bpm <= (i_cfg_wdata > MAX_BPM_LIMIT) ? MAX_BPM_LIMIT : i_cfg_wdata;
            end

            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_op;
                        r_now   <= i_time_ms;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_op == OP_CLEAR) begin
                        r_started <= 1'b0;
                        r_beats   <= '0;
                        r_tempo   <= '0;
                        r_error   <= '0;
                        r_status  <= ST_CLEAR;
                        r_state   <= S_DONE;
                    end else if (!r_started) begin
                        r_started <= 1'b1;
                        r_beats   <= '0;
                        r_start   <= r_now;
                        r_last    <= r_now;
                        r_status  <= ST_FIRST;
                        r_state   <= S_DONE;
                    end else begin
                        r_interval <= r_now - r_last;
                        r_last     <= r_now;
                        r_state    <= S_FAST_MUL;
                    end
                end
                S_FAST_MUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_FAST_CHK;
                end
                S_FAST_CHK: begin
                    if (r_prod < PW'(FAST_LIMIT)) begin
                        r_status <= ST_FAST;
                        r_state  <= S_DONE;
                    end else if (r_beats > BEATS_W'(GAP_LIMIT)) begin
                        r_state <= S_GAP_MUL;
                    end else begin
                        r_state <= S_COUNT;
                    end
                end
                S_GAP_MUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_GAP_CHK;
                end
                S_GAP_CHK: begin
                    if (GAP_PROD < r_prod) begin
                        r_beats  <= '0;
                        r_tempo  <= '0;
                        r_error  <= '0;
                        r_start  <= r_now;
                        r_status <= ST_GAP;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_COUNT;
                    end
                end
                S_COUNT: begin
                    if (r_beats != BEATS_SAT) begin
                        r_beats <= r_beats + 1'b1;
                    end
                    r_status <= ST_BEAT;
                    r_state  <= S_TEMPO_MUL;
                end
                S_TEMPO_MUL: begin
                    // first step tests for a quotient above the 16-bit range
                    r_rem     <= mul_p;
                    r_dvs     <= PW'(elapsed) << QW;
                    r_quo     <= '0;
                    r_cnt     <= CNW'(QW);
                    r_div_err <= 1'b0;
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    if (div_ge) begin
                        r_rem <= div_diff[PW-1:0];
                    end
                    r_quo <= {r_quo[QW-1:0], div_ge};
                    r_dvs <= r_dvs >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= r_div_err ? S_ERR_WB : S_TEMPO_WB;
                    end
                end
                S_TEMPO_WB: begin
                    r_tempo   <= r_quo[QW] ? TEMPO_SAT : r_quo[QW-1:0];
                    r_rem     <= PW'(ERR_SCALE);
                    r_dvs     <= PW'(r_beats) << QW;
                    r_quo     <= '0;
                    r_cnt     <= CNW'(QW);
                    r_div_err <= 1'b1;
                    r_state   <= S_DIV;
                end
                S_ERR_WB: begin
                    r_error <= r_quo[ERR_W-1:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_tempo  <= r_tempo;
                        r_out_error  <= r_error;
                        r_out_beats  <= r_beats;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_bpm_x100   = r_out_tempo;
    assign o_error_x100 = r_out_error;
    assign o_beat_count = r_out_beats;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    a_max_bpm_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max_bpm <= MAX_BPM_LIMIT)
        else $error("max_bpm above limit");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_CLEAR) |->
            (o_bpm_x100 == '0 && o_error_x100 == '0 && o_beat_count == '0))
        else $error("clear result not zero");

    a_beat_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_BEAT) |->
            (o_beat_count != '0 && o_error_x100 <= ERR_SCALE))
        else $error("counted beat with bad count or error");
`endif

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import ttbc_pkg::*;

    localparam int RESTART_MIN_BEATS = 5;
    localparam int END_WAIT          = 60;
    localparam int HOLD_CYCLES       = 250;
    localparam int SHOW_LIMIT        = 10;

    typedef struct packed {
        t_status            status;
        logic [TEMPO_W-1:0] bpm;
        logic [ERR_W-1:0]   err;
        logic [BEATS_W-1:0] beats;
    } t_tap_result;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [MAXB_W-1:0]    cfg_wdata = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_op     = OP_TAP;
    logic [31:0]          in_time   = '0;
    logic                 out_stall = 1'b0;

    logic                 in_stall;
    logic                 out_valid;
    t_status              out_status;
    logic [TEMPO_W-1:0]   out_bpm;
    logic [ERR_W-1:0]     out_err;
    logic [BEATS_W-1:0]   out_beats;

    // tap counter state as the block should hold it
    logic                 tc_started = 1'b0;
    logic [BEATS_W-1:0]   tc_beats   = '0;
    logic [31:0]          tc_start   = '0;
    logic [31:0]          tc_last    = '0;
    logic [TEMPO_W-1:0]   tc_tempo   = '0;
    logic [ERR_W-1:0]     tc_err     = '0;
    logic [MAXB_W-1:0]    tc_max_bpm = MAX_BPM_RESET;

    t_tap_result          tap_results_due[$];

    int                   send_pct    = 0;
    int                   stall_pct   = 0;
    int                   hold_asked  = 0;
    int                   hold_given  = 0;
    int                   hold_left   = 0;
    int                   items_sent  = 0;
    int                   results_seen = 0;
    int                   fail_count  = 0;
    int                   status_seen[0:4] = '{default: 0};

    logic [31:0]          tap_clock  = '0;
    int unsigned          tap_period = 500;

    tap_tempo_bpm_counter_unit u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_op         (in_op),
        .i_time_ms    (in_time),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_status     (out_status),
        .o_bpm_x100   (out_bpm),
        .o_error_x100 (out_err),
        .o_beat_count (out_beats)
    );

    always #1 clk = ~clk;

    function automatic t_tap_result count_tap(input logic op_v, input logic [31:0] now);
        t_tap_result r;
        logic [31:0] gap_ms;
        logic [31:0] run_ms;
        logic [63:0] tempo_wide;
        if (op_v == OP_CLEAR) begin
            tc_started = 1'b0;
            tc_beats   = '0;
            tc_tempo   = '0;
            tc_err     = '0;
            r.status   = ST_CLEAR;
        end else if (!tc_started) begin
            tc_started = 1'b1;
            tc_beats   = '0;
            tc_start   = now;
            tc_last    = now;
            r.status   = ST_FIRST;
        end else begin
            gap_ms  = now - tc_last;
            tc_last = now;
            if (64'(FAST_LIMIT) > 64'(tc_max_bpm) * 64'd2 * 64'(gap_ms)) begin
                r.status = ST_FAST;
            end else if (tc_beats > RESTART_MIN_BEATS &&
                         64'(TEMPO_SCALE) * 64'(RESTART_MIN_BEATS) <
                         64'(tc_tempo) * 64'(gap_ms)) begin
                tc_beats = '0;
                tc_tempo = '0;
                tc_err   = '0;
                tc_start = now;
                r.status = ST_GAP;
            end else begin
                if (tc_beats != BEATS_SAT)
                    tc_beats = tc_beats + 1'b1;
                run_ms = now - tc_start;
                if (run_ms == 0) begin
                    tc_tempo = TEMPO_SAT;
                end else begin
                    tempo_wide = 64'(tc_beats) * 64'(TEMPO_SCALE) / 64'(run_ms);
                    tc_tempo = (tempo_wide > 64'(TEMPO_SAT)) ? TEMPO_SAT
                                                              : tempo_wide[TEMPO_W-1:0];
                end
                tc_err   = ERR_W'(32'(ERR_SCALE) / tc_beats);
                r.status = ST_BEAT;
            end
        end
        r.bpm   = tc_tempo;
        r.err   = tc_err;
        r.beats = tc_beats;
        return r;
    endfunction

    function automatic int unsigned fastest_gap_ms(input logic [MAXB_W-1:0] mb);
        if (mb == 0)
            return 0;
        return (int'(FAST_LIMIT) + 2 * int'(mb) - 1) / (2 * int'(mb));
    endfunction

    task automatic write_max_bpm(input logic [MAXB_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tc_max_bpm = (v > MAX_BPM_LIMIT) ? MAX_BPM_LIMIT : v;
    endtask

    task automatic send_item(input logic op_v, input logic [31:0] t_v);
        while ($urandom_range(0, 99) < send_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op_v;
        in_time  <= t_v;
        do @(posedge clk); while (in_stall);
        tap_results_due.push_back(count_tap(op_v, t_v));
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (tap_results_due.size() != 0);
    endtask

    task automatic pick_tap_period();
        int unsigned lo;
        lo = fastest_gap_ms(tc_max_bpm);
        tap_period = $urandom_range(lo, lo + 1500);
    endtask

    task automatic send_random_tap();
        int unsigned pick;
        logic [31:0] gap;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            pick_tap_period();
            send_item(OP_CLEAR, $urandom);
        end else if (pick < 8) begin
            tap_clock = $urandom;
            send_item(OP_TAP, tap_clock);
        end else begin
            if (pick < 16)
                gap = $urandom_range(0, fastest_gap_ms(tc_max_bpm));
            else if (pick < 24)
                gap = tap_period * $urandom_range(3, 9);
            else
                gap = tap_period - tap_period / 8 + $urandom_range(0, tap_period / 4);
            if (pick == 30)
                pick_tap_period();
            tap_clock = tap_clock + gap;
            send_item(OP_TAP, tap_clock);
        end
    endtask

    task automatic run_random_phase(input int n, input int s_pct, input int r_pct,
                                    input logic [MAXB_W-1:0] mb);
        drain_results();
        write_max_bpm(mb);
        send_pct  = s_pct;
        stall_pct <= r_pct;
        tap_clock = $urandom;
        pick_tap_period();
        repeat (n) send_random_tap();
    endtask

    task automatic test_tap_sequence();
        send_item(OP_CLEAR, 32'hFFFF_FFFF);
        send_item(OP_TAP, 32'd1000);
        send_item(OP_TAP, 32'd1000);
        send_item(OP_TAP, 32'd1119);
        send_item(OP_TAP, 32'd1239);
        for (int i = 1; i <= 5; i++)
            send_item(OP_TAP, 32'd1239 + 32'(500 * i));
        send_item(OP_TAP, 32'd8739);
        send_item(OP_TAP, 32'd9339);
        send_item(OP_CLEAR, 32'h0);
    endtask

    task automatic test_clock_wrap();
        send_item(OP_TAP, 32'h0000_0000);
        send_item(OP_TAP, 32'h8000_0000);
        send_item(OP_TAP, 32'h0000_0000);
        send_item(OP_TAP, 32'hFFFF_FFFF);
    endtask

    task automatic test_tempo_limit();
        drain_results();
        write_max_bpm(8'd255);
        send_item(OP_CLEAR, $urandom);
        send_item(OP_TAP, 32'd5000);
        send_item(OP_TAP, 32'd5118);
        drain_results();
        write_max_bpm(8'd0);
        send_item(OP_TAP, 32'd10118);
        drain_results();
        write_max_bpm(8'd50);
        send_item(OP_TAP, 32'd10717);
        send_item(OP_TAP, 32'd11317);
    endtask

    task automatic test_backpressure();
        drain_results();
        write_max_bpm(MAX_BPM_RESET);
        send_pct   = 0;
        stall_pct  <= 0;
        hold_asked <= hold_asked + 1;
        pick_tap_period();
        repeat (15) begin
            tap_clock = tap_clock + tap_period;
            send_item(OP_TAP, tap_clock);
        end
        drain_results();
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_asked != hold_given) begin
            hold_given <= hold_asked;
            hold_left  <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk) begin : check_results
        t_tap_result want;
        t_tap_result got;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            got.status = out_status;
            got.bpm    = out_bpm;
            got.err    = out_err;
            got.beats  = out_beats;
            if (tap_results_due.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOW_LIMIT)
                    $display("unexpected item: status %0d bpm %0d err %0d beats %0d",
                             got.status, got.bpm, got.err, got.beats);
            end else begin
                want = tap_results_due.pop_front();
                status_seen[want.status]++;
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= SHOW_LIMIT)
                        $display({"mismatch: exp st %0d bpm %0d err %0d beats %0d, ",
                                  "got st %0d bpm %0d err %0d beats %0d"},
                                 want.status, want.bpm, want.err, want.beats,
                                 got.status, got.bpm, got.err, got.beats);
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_tap_sequence();
        test_clock_wrap();
        test_tempo_limit();
        test_backpressure();
        run_random_phase(92, 0, 0, MAX_BPM_RESET);
        run_random_phase(92, 59, 0, 8'd50);
        run_random_phase(92, 0, 59, 8'($urandom_range(50, 250)));
        run_random_phase(92, 24, 24, 8'd255);
        drain_results();
        repeat (END_WAIT) @(posedge clk);
        if (tap_results_due.size() != 0) begin
            $display("%0d items never came out", tap_results_due.size());
            fail_count += tap_results_due.size();
        end
        $display("%0d items in, %0d checked: first %0d, beat %0d, fast %0d, restart %0d, clear %0d",
                 items_sent, results_seen, status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3], status_seen[4]);
        $display("tempo limits 0, 50, 250, random and clamped; four idle mixes and a long hold");
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("timed out");
        $display("FAIL");
        $finish;
    end

endmodule
